// ===== hdl/stepper_full_step_sequencer_macros.svh =====
// Assertion macros shared by the stepper sequencer modules.
`ifndef STEPPER_FULL_STEP_SEQUENCER_MACROS_SVH
`define STEPPER_FULL_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/stp_pkg.sv =====
// Package with request/response types, codes and constants of the stepper sequencer.
package stp_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_REV = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INTERVAL = 1'b1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   localparam logic [15:0] STEPS_PER_REV_RESET = 16'd200;
   localparam logic [31:0] STEP_INTERVAL_RESET = 32'd1000;
   localparam logic [14:0] PENDING_STEPS_MAX   = 15'h7FFF;
   localparam logic [31:0] ELAPSED_MAX         = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               op;
      logic signed [15:0] move_steps;
   } req_type;

   typedef struct packed {
      logic [3:0]  coils;
      logic [15:0] position;
      logic [14:0] pending_steps;
      logic        stepped;
      logic        busy_res;
   } rsp_type;

   function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
      logic [3:0] pat;
      case (phase)
         2'd0:    pat = 4'd3;
         2'd1:    pat = 4'd6;
         2'd2:    pat = 4'd12;
         default: pat = 4'd9;
      endcase
      return pat;
   endfunction

endpackage

// ===== hdl/stp_core.sv =====
// Motion state, configuration registers and per-request step logic.
`include "stepper_full_step_sequencer_macros.svh"

module stp_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  stp_pkg::req_type               item,
   input  logic                           csr_we,
   input  logic [stp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output stp_pkg::rsp_type               result
);
   import stp_pkg::*;

   logic [15:0] steps_per_rev_ff;
   logic [31:0] step_interval_ff;
   logic [15:0] position_ff, position_in;
   logic        forward_ff, forward_in;
   logic [14:0] remaining_ff, remaining_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [3:0]  coil_ff, coil_in;

   logic [15:0] rev_len;
   logic [16:0] pos_inc;
   logic [15:0] pos_step;
   logic [15:0] mag;
   logic [31:0] elapsed_inc;
   logic        do_step;

   always_comb begin
      rev_len  = (steps_per_rev_ff == 16'd0) ? 16'd1 : steps_per_rev_ff;
      pos_inc  = {1'b0, position_ff} + 17'd1;
      if (forward_ff) begin
         pos_step = (pos_inc >= {1'b0, rev_len}) ? 16'd0 : pos_inc[15:0];
      end else if (position_ff == 16'd0 || position_ff >= rev_len) begin
         pos_step = rev_len - 16'd1;
      end else begin
         pos_step = position_ff - 16'd1;
      end
      mag         = item.move_steps[15] ? (16'd0 - item.move_steps) : item.move_steps;
      elapsed_inc = (elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 32'd1 : elapsed_ff;
      do_step     = (item.op == OP_TICK) && (remaining_ff != 15'd0)
                    && (elapsed_inc >= step_interval_ff);

      position_in  = position_ff;
      forward_in   = forward_ff;
      remaining_in = remaining_ff;
      elapsed_in   = elapsed_ff;
      coil_in      = coil_ff;
      if (item.op == OP_MOVE) begin
         if (item.move_steps[15]) begin
            forward_in = 1'b0;
         end else if (item.move_steps != 16'sd0) begin
            forward_in = 1'b1;
         end
         remaining_in = mag[15] ? PENDING_STEPS_MAX : mag[14:0];
      end else if (do_step) begin
         elapsed_in   = 32'd0;
         position_in  = pos_step;
         remaining_in = remaining_ff - 15'd1;
         coil_in      = coil_pattern(pos_step[1:0]);
      end else begin
         elapsed_in = elapsed_inc;
      end

      result.coils         = coil_in;
      result.position      = position_in;
      result.pending_steps = remaining_in;
      result.stepped       = do_step;
      result.busy_res      = (remaining_in != 15'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_rev_ff <= STEPS_PER_REV_RESET;
         step_interval_ff <= STEP_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEPS_PER_REV: steps_per_rev_ff <= csr_wdata[15:0];
            CSR_STEP_INTERVAL: step_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= 16'd0;
         forward_ff   <= 1'b0;
         remaining_ff <= 15'd0;
         elapsed_ff   <= 32'd0;
         coil_ff      <= 4'd0;
      end else if (step_en) begin
         position_ff  <= position_in;
         forward_ff   <= forward_in;
         remaining_ff <= remaining_in;
         elapsed_ff   <= elapsed_in;
         coil_ff      <= coil_in;
      end
   end

   `STP_ASSERT_NOW(a_step_needs_work, step_en && result.stepped,
      item.op == OP_TICK && remaining_ff != 15'd0, "step taken without pending steps")
   `STP_ASSERT_NOW(a_step_in_range, step_en && result.stepped,
      result.position < rev_len, "stepped position outside revolution")
   `STP_ASSERT_NEXT(a_step_clears_elapsed, step_en && result.stepped,
      elapsed_ff == 32'd0, "elapsed not restarted after step")

endmodule

// ===== hdl/stepper_full_step_sequencer.sv =====
// Top level of the two-phase-on full-step stepper sequencer.
//
// Requests enter on req_valid/req_stall/req_data: a tick (op = OP_TICK)
// advances the elapsed counter and may take one step; a move (op = OP_MOVE)
// loads a signed step count whose sign sets direction.
// Every request yields one response on rsp_valid/rsp_stall/rsp_data with the
// coil pattern, position, pending steps, step flag and busy flag.
// csr_we/csr_index/csr_wdata write steps_per_rev (index 0) and step_interval
// (index 1); write only while no request is in flight.
// A request is held in the request register, and its response is loaded into
// the response register once that register is free. Throughput: one request
// per cycle, sustained while rsp_stall is low; the motion state is computed
// combinationally between the request register and the response register.
// Reset: synchronous, clears both stages, position, direction (reverse),
// pending steps, elapsed count and coils; registers return to 200 and 1000.
// When rsp_stall holds a response, one more request is taken into the request
// register, and req_stall rises until the response is taken.
`include "stepper_full_step_sequencer_macros.svh"

module stepper_full_step_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  stp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output stp_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [stp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import stp_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_ready;
   logic    advance;
   logic    req_take;

   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_ready;
      req_stall    = in_valid_ff && !out_ready;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   stp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (in_data_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `STP_ASSERT_NOW(a_stall_only_when_full, req_stall,
      in_valid_ff && out_valid_ff && rsp_stall, "request stalled with free stage")
   `STP_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff,
      "response register not loaded")
   `STP_ASSERT_NEXT(a_stalled_rsp_held, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

// ===== tb/stepper_full_step_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the full-step stepper sequencer with a scoreboard class.
module stepper_full_step_sequencer_tb;
   import stp_pkg::*;

   class motion_scoreboard;
      rsp_type     expected_rsps[$];
      int unsigned mismatches;
      logic [15:0] steps_per_rev;
      logic [31:0] step_interval;
      logic [15:0] position;
      logic        forward;
      logic [14:0] remaining;
      logic [31:0] elapsed;
      logic [3:0]  coils;
      logic [3:0]  phase_coils [4];

      function new();
         mismatches    = 0;
         steps_per_rev = STEPS_PER_REV_RESET;
         step_interval = STEP_INTERVAL_RESET;
         position      = '0;
         forward       = 1'b0;
         remaining     = '0;
         elapsed       = '0;
         coils         = '0;
         phase_coils[0] = 4'd3;
         phase_coils[1] = 4'd6;
         phase_coils[2] = 4'd12;
         phase_coils[3] = 4'd9;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_STEPS_PER_REV: steps_per_rev = value[15:0];
            CSR_STEP_INTERVAL: step_interval = value;
            default: ;
         endcase
      endfunction

      function void take_step();
         int unsigned rev;
         int unsigned nxt;
         rev = (steps_per_rev == 0) ? 1 : steps_per_rev;
         if (forward) begin
            nxt = position + 1;
            position = (nxt >= rev) ? 16'd0 : 16'(nxt);
         end else if (position == 0 || position >= rev) begin
            position = 16'(rev - 1);
         end else begin
            position = position - 16'd1;
         end
         remaining = remaining - 15'd1;
         coils = phase_coils[position[1:0]];
      endfunction

      function void note_request(req_type r);
         int      count;
         int      mag;
         rsp_type predicted;
         logic    stepped;
         stepped = 1'b0;
         if (r.op == OP_MOVE) begin
            count = int'($signed(r.move_steps));
            if (count < 0) begin
               forward = 1'b0;
               mag = -count;
            end else begin
               if (count != 0) forward = 1'b1;
               mag = count;
            end
            remaining = (mag > int'(PENDING_STEPS_MAX)) ? PENDING_STEPS_MAX : 15'(mag);
         end else begin
            if (elapsed != ELAPSED_MAX) elapsed = elapsed + 32'd1;
            if (remaining != 0 && elapsed >= step_interval) begin
               elapsed = '0;
               take_step();
               stepped = 1'b1;
            end
         end
         predicted.coils         = coils;
         predicted.position      = position;
         predicted.pending_steps = remaining;
         predicted.stepped       = stepped;
         predicted.busy_res      = (remaining != 0);
         expected_rsps.push_back(predicted);
      endfunction

      function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, act_v);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request pending: %h", $realtime, got);
            return;
         end
         want = expected_rsps.pop_front();
         compare_field("coils", want.coils, got.coils);
         compare_field("position", want.position, got.position);
         compare_field("pending_steps", want.pending_steps, got.pending_steps);
         compare_field("stepped", want.stepped, got.stepped);
         compare_field("busy_res", want.busy_res, got.busy_res);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   motion_scoreboard sb;
   int unsigned      idle_pct;
   logic             quiet;
   logic             long_hold;

   stepper_full_step_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("stepper_full_step_sequencer_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (80) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_request(logic op, logic [15:0] steps);
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data.op         = op;
      req_data.move_steps = steps;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_request(OP_TICK, 16'($urandom));
   endtask

   task automatic send_move(int count);
      send_request(OP_MOVE, 16'(count));
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (sb.expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      sb.set_register(index, value);
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = 32'($urandom);
   endtask

   task automatic configure(logic [15:0] spr, logic [31:0] interval);
      settle();
      write_csr(CSR_STEPS_PER_REV, {16'($urandom), spr});
      write_csr(CSR_STEP_INTERVAL, interval);
   endtask

   function automatic logic [15:0] pick_rev();
      logic [15:0] spr;
      case ($urandom_range(0, 9))
         0:       spr = 16'd0;
         1:       spr = 16'd1;
         2:       spr = 16'hFFFF;
         3:       spr = 16'd200;
         4:       spr = 16'($urandom);
         default: spr = 16'($urandom_range(2, 9));
      endcase
      return spr;
   endfunction

   function automatic logic [31:0] pick_interval();
      logic [31:0] interval;
      case ($urandom_range(0, 7))
         0:       interval = 32'd0;
         1:       interval = 32'd1;
         2:       interval = 32'($urandom_range(6, 40));
         default: interval = 32'($urandom_range(2, 5));
      endcase
      return interval;
   endfunction

   task automatic send_random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         send_ticks(1);
      end else if (pick < 85) begin
         send_move($urandom_range(0, 1) ? int'($urandom_range(1, 12)) : -int'($urandom_range(1, 12)));
      end else if (pick < 92) begin
         send_request(OP_MOVE, 16'($urandom));
      end else begin
         case ($urandom_range(0, 5))
            0:       send_move(0);
            1:       send_move(32767);
            2:       send_move(-32767);
            3:       send_move(-32768);
            4:       send_move(1);
            default: send_move(-1);
         endcase
      end
   endtask

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_STEPS_PER_REV;
      csr_wdata = '0;
      idle_pct  = 10;
      quiet     = 1'b0;
      long_hold = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_ticks(1);
      send_move(2);
      send_ticks(2);

      configure(16'hFFFF, 32'd0);
      send_move(-1);
      send_ticks(2);
      send_move(-32768);
      send_ticks(2);
      send_move(0);
      send_ticks(1);
      send_move(32767);
      send_move(-3);
      send_ticks(3);

      configure(16'd3, 32'd0);
      send_move(1);
      send_ticks(1);

      configure(16'hFFFF, 32'd0);
      send_move(-2);
      send_ticks(2);

      configure(16'd2, 32'd1);
      send_move(-1);
      send_ticks(2);

      configure(16'd0, 32'd1);
      send_move(3);
      send_ticks(4);

      configure(16'd1, 32'hFFFF_FFFF);
      send_move(-5);
      send_ticks(3);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3)
            configure(pick_rev(), 32'hFFFF_FFFF);
         else if (phase == 5)
            configure(16'd7, 32'd0);
         else
            configure(pick_rev(), pick_interval());
         idle_pct = (phase == 5) ? 0 : $urandom_range(5, 35);
         quiet    = (phase == 7);
         for (int n = 0; n < 150; n++) begin
            if (phase == 2 && n == 40) long_hold = 1'b1;
            send_random_item();
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_rsps.size() == 0)
         $display("stepper_full_step_sequencer_tb: clean");
      else
         $display("stepper_full_step_sequencer_tb: errors");
      $finish;
   end
endmodule
